### rtl/core/mscd_pkg.sv
`default_nettype none
package mscd_pkg;
	localparam int SLOT_COUNT = 8;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam logic [16:0] DUR_MASK = 17'h1FFFF;

	localparam logic [3:0] OP_TICK = 4'd0;
	localparam logic [3:0] OP_LIGHT = 4'd1;
	localparam logic [3:0] OP_ALARM = 4'd2;
	localparam logic [3:0] OP_LIGHT_LONG = 4'd3;
	localparam logic [3:0] OP_ALARM_LONG = 4'd4;
	localparam logic [3:0] OP_ALARM_REL = 4'd5;
	localparam logic [3:0] OP_EXPIRE = 4'd6;
	localparam logic [3:0] OP_CHIME_DONE = 4'd7;
	localparam logic [3:0] OP_TIMEOUT = 4'd8;
	localparam logic [3:0] OP_ACTIVATE = 4'd9;
	localparam logic [3:0] OP_RESIGN = 4'd10;

	localparam logic [1:0] MODE_WAIT = 2'd0;
	localparam logic [1:0] MODE_RUN = 2'd1;
	localparam logic [1:0] MODE_PAUSE = 2'd2;
	localparam logic [1:0] MODE_SET = 2'd3;

	localparam logic [2:0] STEP_SLOT = 3'd0;
	localparam logic [2:0] STEP_CLEAR = 3'd1;
	localparam logic [2:0] STEP_HOURS = 3'd2;
	localparam logic [2:0] STEP_MINUTES = 3'd3;
	localparam logic [2:0] STEP_SECONDS = 3'd4;
	localparam logic [2:0] STEP_LOOP = 3'd5;

	localparam logic [1:0] RATE_NONE = 2'd0;
	localparam logic [1:0] RATE_1HZ = 2'd1;
	localparam logic [1:0] RATE_4HZ = 2'd2;
	localparam logic [1:0] RATE_8HZ = 2'd3;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_LOAD} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic scan;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_done;
		logic out_busy;
	} dp_status_t;

	function automatic logic [16:0] seconds_of(input logic [17:0] v);
		return 17'(v[4:0]) * 17'd3600 + 17'(v[10:5]) * 17'd60 + 17'(v[16:11]);
	endfunction

	function automatic logic [17:0] default_slot(input int i);
		case (i)
			0: return 18'(2 << 5);
			1: return 18'(5 << 5);
			2: return 18'(10 << 5);
			3: return 18'(20 << 5);
			4: return 18'(2 | (45 << 5));
			default: return 18'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

### rtl/core/mscd_ctrl.sv
`default_nettype none
module mscd_ctrl import mscd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output dp_cmd_t cmd,
	input wire dp_status_t status
);
	ctrl_state_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		cmd = '0;
		in_ready = 1'b0;
		case (st_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					st_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				st_d = status.need_scan ? S_SCAN : S_LOAD;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) st_d = S_LOAD;
			end
			S_LOAD: begin
				if (!status.out_busy) begin
					cmd.load = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while one is in work");
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SCAN && status.scan_done) |=> st_q == S_LOAD)
		else $error("scan end not followed by load");
	a_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EXEC && !status.need_scan) |=> st_q == S_LOAD)
		else $error("exec without scan skipped load");
endmodule
`default_nettype wire

### rtl/core/mscd_datapath.sv
`default_nettype none
module mscd_datapath import mscd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire dp_cmd_t cmd,
	output dp_status_t status,
	input wire logic [3:0] in_op,
	input wire logic in_held,
	output logic [33:0] out_data,
	output logic out_valid,
	input wire logic out_ready
);
	logic [3:0] op_q;
	logic held_q;
	logic [1:0] mode_q;
	logic [2:0] step_q;
	logic [SLOT_W-1:0] cur_q, prev_q, base_q, idx_q;
	logic [16:0] rem_q;
	logic [7:0] pt_q;
	logic erase_q, quick_q, bell_q;
	logic [2:0] chimes_q;
	logic [17:0] store_q [SLOT_COUNT];
	logic click_q, chime_q, light_q, leave_q;
	logic [1:0] rate_q;
	logic [33:0] out_q;
	logic out_v_q;

	logic [1:0] n_mode;
	logic [2:0] n_step;
	logic [SLOT_W-1:0] n_cur, n_prev, nxt_idx;
	logic [16:0] n_rem;
	logic [7:0] n_pt;
	logic n_erase, n_quick, n_bell, n_scan;
	logic [2:0] n_chimes;
	logic n_click, n_chime, n_light, n_leave, do_draw;
	logic [1:0] n_rate;
	logic st_we;
	logic [17:0] st_wd, v, nv, rd;
	logic [6:0] fld;
	logic [3:0] stp;
	logic [16:0] shown;

	assign rd = store_q[cmd.scan ? idx_q : cur_q];
	assign v = store_q[cur_q];

	function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] c);
		return (c == SLOT_W'(SLOT_COUNT - 1)) ? '0 : c + 1'b1;
	endfunction

	always_comb begin
		n_mode = mode_q; n_step = step_q; n_cur = cur_q; n_prev = prev_q;
		n_rem = rem_q; n_pt = pt_q; n_erase = erase_q; n_quick = quick_q;
		n_bell = bell_q; n_chimes = chimes_q; n_scan = 1'b0;
		n_click = 1'b0; n_chime = 1'b0; n_light = 1'b0; n_leave = 1'b0;
		n_rate = RATE_NONE; do_draw = 1'b0;
		st_we = 1'b0; st_wd = v; nv = v; fld = '0; stp = '0;

		// increment of the field picked by step, shared by tick and alarm press
		if ((op_q == OP_TICK && mode_q != MODE_RUN && mode_q != MODE_PAUSE
				&& quick_q && held_q) || (op_q == OP_ALARM && chimes_q == '0
				&& mode_q == MODE_SET)) begin
			case (step_q)
				STEP_SLOT: n_cur = wrap_inc(cur_q);
				STEP_CLEAR: n_erase = ~erase_q;
				STEP_HOURS: begin
					fld = 7'(v[4:0]) + 7'd1;
					if (fld >= 7'd24) fld = fld - 7'd24;
					st_we = 1'b1; st_wd = {v[17:5], fld[4:0]};
				end
				STEP_MINUTES: begin
					fld = 7'(v[10:5]) + 7'd1;
					if (fld >= 7'd60) fld = fld - 7'd60;
					st_we = 1'b1; st_wd = {v[17:11], fld[5:0], v[4:0]};
				end
				STEP_SECONDS: begin
					fld = 7'(v[16:11]) + 7'd1;
					if (fld >= 7'd60) fld = fld - 7'd60;
					st_we = 1'b1; st_wd = {v[17], fld[5:0], v[10:0]};
				end
				STEP_LOOP: begin
					st_we = 1'b1; st_wd = {~v[17], v[16:0]};
				end
				default: ;
			endcase
		end

		case (op_q)
			OP_TICK: begin
				if (mode_q == MODE_RUN) begin
					if (rem_q != '0) n_rem = rem_q - 1'b1;
				end else if (mode_q == MODE_PAUSE) n_pt = pt_q + 1'b1;
				else if (quick_q && !held_q) begin
					n_quick = 1'b0; n_rate = RATE_4HZ;
				end
				do_draw = 1'b1;
			end
			OP_LIGHT: begin
				case (mode_q)
					MODE_PAUSE: begin n_mode = MODE_WAIT; n_bell = 1'b0; n_click = 1'b1; end
					MODE_RUN: n_light = 1'b1;
					MODE_SET: begin
						if (erase_q) begin
							nv = '0; st_we = 1'b1; st_wd = '0; n_erase = 1'b0;
						end
						stp = 4'(step_q) + 4'd1;
						if (stp >= 4'd6) stp = stp - 4'd6;
						n_step = stp[2:0];
						if (n_step == STEP_CLEAR && nv == '0) n_step = STEP_HOURS;
						else if (n_step == STEP_LOOP && (nv[16:0] & DUR_MASK) == '0)
							n_step = STEP_SLOT;
					end
					default: begin
						n_prev = cur_q; n_cur = wrap_inc(cur_q); n_scan = 1'b1;
					end
				endcase
				do_draw = 1'b1;
			end
			OP_ALARM: begin
				if (quick_q) begin n_quick = 1'b0; n_rate = RATE_4HZ; end
				if (chimes_q != '0) n_chimes = '0;
				else begin
					case (mode_q)
						MODE_RUN: begin n_mode = MODE_PAUSE; n_pt = '0; n_click = 1'b1; end
						MODE_SET: ;
						default: begin
							n_click = 1'b1;
							if (v[16:0] != '0) begin
								if (mode_q != MODE_PAUSE) n_rem = seconds_of(v);
								n_mode = MODE_RUN; n_bell = 1'b1;
							end
						end
					endcase
					do_draw = 1'b1;
				end
			end
			OP_LIGHT_LONG: begin
				if (mode_q == MODE_WAIT) begin
					n_cur = prev_q; n_mode = MODE_SET; n_step = STEP_SLOT; n_erase = 1'b0;
					n_rate = RATE_4HZ; n_click = 1'b1;
				end else if (mode_q == MODE_SET) begin
					n_step = STEP_SLOT; n_mode = MODE_WAIT; n_rate = RATE_1HZ;
					n_scan = 1'b1; n_click = 1'b1;
				end
				do_draw = 1'b1;
			end
			OP_ALARM_LONG: begin
				if (mode_q == MODE_SET) begin
					if (step_q == STEP_SLOT) n_cur = '0;
					else if (step_q >= STEP_HOURS && step_q <= STEP_SECONDS) begin
						n_quick = 1'b1; n_rate = RATE_8HZ;
					end
				end
				do_draw = 1'b1;
			end
			OP_ALARM_REL: if (quick_q) begin n_quick = 1'b0; n_rate = RATE_4HZ; end
			OP_EXPIRE: begin
				n_chimes = 3'd4; n_chime = 1'b1; n_mode = MODE_WAIT; n_bell = 1'b0;
				if (v[17] && v[16:0] != '0) begin
					n_rem = seconds_of(v); n_mode = MODE_RUN; n_bell = 1'b1;
				end
			end
			OP_CHIME_DONE: if (chimes_q != '0) begin
				n_chimes = chimes_q - 1'b1; n_chime = 1'b1;
			end
			OP_TIMEOUT: begin
				if (quick_q) begin n_quick = 1'b0; n_rate = RATE_4HZ; end
				n_leave = 1'b1;
			end
			OP_ACTIVATE: begin
				if (mode_q == MODE_RUN) n_bell = 1'b1;
				else begin n_pt = 8'd1; n_chimes = '0; end
				do_draw = 1'b1;
			end
			OP_RESIGN: if (mode_q == MODE_SET) begin n_step = STEP_SLOT; n_mode = MODE_WAIT; end
			default: ;
		endcase
		if (do_draw && n_mode == MODE_PAUSE) n_bell = ~n_pt[0];
	end

	assign nxt_idx = wrap_inc(idx_q);
	assign status.need_scan = n_scan;
	assign status.scan_done = (rd[16:0] != '0) || (nxt_idx == base_q);
	assign status.out_busy = out_v_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_WAIT; step_q <= STEP_SLOT; cur_q <= '0; prev_q <= '0;
			rem_q <= '0; pt_q <= '0; erase_q <= 1'b0; quick_q <= 1'b0;
			bell_q <= 1'b0; chimes_q <= '0; out_v_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) store_q[i] <= default_slot(i);
		end else begin
			if (cmd.exec) begin
				mode_q <= n_mode; step_q <= n_step; cur_q <= n_cur; prev_q <= n_prev;
				rem_q <= n_rem; pt_q <= n_pt; erase_q <= n_erase; quick_q <= n_quick;
				bell_q <= n_bell; chimes_q <= n_chimes;
				if (st_we) store_q[cur_q] <= st_wd;
			end
			if (cmd.scan) begin
				if (rd[16:0] != '0) cur_q <= idx_q;
				else if (nxt_idx == base_q) cur_q <= base_q;
			end
			if (cmd.load) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin op_q <= in_op; held_q <= in_held; end
		if (cmd.exec) begin
			base_q <= n_cur; idx_q <= n_cur;
			click_q <= n_click; chime_q <= n_chime; rate_q <= n_rate;
			light_q <= n_light; leave_q <= n_leave;
		end
		if (cmd.scan && rd[16:0] == '0) idx_q <= nxt_idx;
		if (cmd.load) out_q <= {leave_q, light_q, rate_q, chime_q, click_q, bell_q,
			erase_q, v[17], shown, 3'(cur_q), step_q, mode_q};
	end

	assign shown = (mode_q == MODE_RUN || mode_q == MODE_PAUSE) ? rem_q : seconds_of(v);
	assign out_data = out_q;
	assign out_valid = out_v_q;
endmodule
`default_nettype wire

### rtl/core/multi_slot_countdown_timer_control_top.sv
// Countdown timer controller with eight preset slots.
// Slave stream s_axis carries one event item: tdata[3:0] op, tdata[4] alarm_held.
// Master stream m_axis returns one result item per event (fields in port comment).
// One item is in work at a time. After acceptance the controller applies the
// event in its exec state, then for a slot scan (light press while waiting,
// light long press leaving setting) steps through the slots in its scan state
// until one holds a nonzero duration or all eight were visited, then loads the
// output register in its load state; s_axis_tready returns in the cycle after
// the load.
// While m_axis_tvalid is held by a stalled receiver the result stays put; the
// next event may be accepted and worked on, and waits before load until the
// output register is taken.
// Reset (arst_n low) returns to waiting with the five default slot durations
// (2, 5, 10, 20 min and 2 h 45 min), other slots zero, and no result pending.
`default_nettype none
module multi_slot_countdown_timer_control_top import mscd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata, // op[3:0], alarm_held[4], zero pad
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// mode[1:0], setting_step[4:2], slot[7:5], shown_time[24:8], repeat_on[25],
	// erase_pending[26], bell_on[27], click[28], chime_start[29], rate_code[31:30],
	// light_request[32], leave_face[33], zero pad
	output logic [39:0] m_axis_tdata
);
	dp_cmd_t cmd;
	dp_status_t status;
	logic [33:0] out_data;

	mscd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.cmd(cmd), .status(status)
	);

	mscd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.in_op(s_axis_tdata[3:0]), .in_held(s_axis_tdata[4]),
		.out_data(out_data), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready)
	);

	assign m_axis_tdata = {6'd0, out_data};
endmodule
`default_nettype wire
